// ===== hw/rtl/mcst_pkg.sv =====
`default_nettype none

package mcst_pkg;

	// Default sizing
	localparam int unsigned NUM_CHANNELS_DEF = 16;
	localparam int unsigned COUNT_BITS_DEF   = 32;

	// Width used to compare channel numbers of any supported table size
	localparam int unsigned IDX_CMP_W = 8;

	// Command codes
	localparam logic [2:0] FN_CREATE     = 3'd0;
	localparam logic [2:0] FN_ARM        = 3'd1;
	localparam logic [2:0] FN_CANCEL     = 3'd2;
	localparam logic [2:0] FN_RESTART    = 3'd3;
	localparam logic [2:0] FN_TICK       = 3'd4;
	localparam logic [2:0] FN_CREATE_ARM = 3'd5;

	// Result kinds
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOCHAN   = 2'd1;
	localparam logic [1:0] ST_NOTARMED = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Command transaction
	typedef struct packed {
		logic [2:0]  func;
		logic [3:0]  timer_id;
		logic [31:0] duration;
		logic        repeat_req;
	} cmd_t;

	// Result transaction
	typedef struct packed {
		logic       kind;
		logic [3:0] channel;
		logic [1:0] status;
		logic       last;
	} evt_t;

	// Per-channel control flags held in each cell
	typedef struct packed {
		logic exists;
		logic active;
		logic periodic;
		logic armed;
	} chan_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcst_cell.sv =====
`default_nettype none

module mcst_cell
	import mcst_pkg::*;
#(
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  shift_en,
	input  wire chan_flags_t           flags_in,
	input  wire logic [COUNT_BITS-1:0] interval_in,
	input  wire logic [COUNT_BITS-1:0] remaining_in,
	output chan_flags_t                flags_q,
	output logic [COUNT_BITS-1:0]      interval_q,
	output logic [COUNT_BITS-1:0]      remaining_q
);

	// Flags reset to an empty channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (shift_en) begin
			flags_q <= flags_in;
		end
	end

	// Counts are only read once the channel was armed
	always_ff @(posedge clk) begin
		if (shift_en) begin
			interval_q  <= interval_in;
			remaining_q <= remaining_in;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_channel_software_timer_core.sv =====
`default_nettype none

// Channel | Direction | Handshake             | Payload
// cmd     | in        | cmd_valid / cmd_ready | cmd_t: func, timer_id, duration, repeat_req
// evt     | out       | evt_valid / evt_ready | evt_t: kind, channel, status, last
//
// Channel records sit in a ring of NUM_CHANNELS cells that rotates one place per
// cycle whenever shift_en is set; the controller works only on the record at the head.
// A command that addresses a channel first rotates the ring to that channel.
// A tick rotates the ring to channel 0, sweeps every channel once for the countdown,
// and then flushes the final expiry.
// Reset empties every channel at once; no clearing pass is needed.
// A full result register holds the ring still, where a result must be pushed, until evt_ready takes the result.

module multi_channel_software_timer_core
	import mcst_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      evt_valid,
	input  wire logic evt_ready,
	output evt_t      evt
);

	localparam int unsigned CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned NF_W    = $clog2(NUM_CHANNELS + 1);
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_SEEK,
		S_SWEEP,
		S_FLUSH
	} state_t;

	state_t                state_q;
	logic [CH_W-1:0]       head_q;
	logic [CH_W-1:0]       target_q;
	logic [NF_W-1:0]       next_free_q;
	logic [2:0]            func_q;
	logic [COUNT_BITS-1:0] dur_q;
	logic                  rep_q;
	logic [3:0]            resp_ch_q;
	logic [1:0]            resp_st_q;
	logic                  pend_valid_q;
	logic [3:0]            pend_ch_q;
	logic                  evt_valid_q;
	evt_t                  evt_q;

	// Ring of cells
	chan_flags_t           cell_flags [NUM_CHANNELS];
	logic [COUNT_BITS-1:0] cell_int   [NUM_CHANNELS];
	logic [COUNT_BITS-1:0] cell_rem   [NUM_CHANNELS];
	chan_flags_t           tail_flags;
	logic [COUNT_BITS-1:0] tail_int;
	logic [COUNT_BITS-1:0] tail_rem;
	logic                  shift_en;

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
		chan_flags_t           nxt_flags;
		logic [COUNT_BITS-1:0] nxt_int;
		logic [COUNT_BITS-1:0] nxt_rem;

		if (i == NUM_CHANNELS - 1) begin : g_tail
			assign nxt_flags = tail_flags;
			assign nxt_int   = tail_int;
			assign nxt_rem   = tail_rem;
		end else begin : g_mid
			assign nxt_flags = cell_flags[i+1];
			assign nxt_int   = cell_int[i+1];
			assign nxt_rem   = cell_rem[i+1];
		end

		mcst_cell #(
			.COUNT_BITS(COUNT_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift_en    (shift_en),
			.flags_in    (nxt_flags),
			.interval_in (nxt_int),
			.remaining_in(nxt_rem),
			.flags_q     (cell_flags[i]),
			.interval_q  (cell_int[i]),
			.remaining_q (cell_rem[i])
		);
	end

	// Head record and derived terms
	chan_flags_t           head_flags;
	logic [COUNT_BITS-1:0] head_int;
	logic [COUNT_BITS-1:0] head_rem;
	logic                  head_exp;
	logic                  evt_free;
	logic [IDX_CMP_W-1:0]  head_ext;

	assign head_flags = cell_flags[0];
	assign head_int   = cell_int[0];
	assign head_rem   = cell_rem[0];
	assign head_exp   = head_flags.exists && head_flags.active &&
	                    (head_rem <= COUNT_BITS'(1));
	assign evt_free   = !evt_valid_q || evt_ready;
	assign head_ext   = IDX_CMP_W'(head_q);

	// Accept-time decode
	logic [IDX_CMP_W-1:0]  id_ext;
	logic [IDX_CMP_W-1:0]  nf_ext;
	logic [63:0]           dur_wide;
	logic                  id_ok;
	logic                  table_full;

	assign id_ext     = IDX_CMP_W'(cmd.timer_id);
	assign nf_ext     = IDX_CMP_W'(next_free_q);
	assign dur_wide   = 64'(cmd.duration);
	assign id_ok      = id_ext < IDX_CMP_W'(NUM_CHANNELS);
	assign table_full = next_free_q == NF_W'(NUM_CHANNELS);
	assign cmd_ready  = (state_q == S_IDLE);

	// Head update, ring shift and result push
	logic push;
	evt_t push_data;
	logic act;

	always_comb begin
		shift_en   = 1'b0;
		act        = 1'b0;
		push       = 1'b0;
		push_data  = '0;
		tail_flags = head_flags;
		tail_int   = head_int;
		tail_rem   = head_rem;

		case (state_q)
			S_RESP: begin
				if (evt_free) begin
					push      = 1'b1;
					push_data = '{kind: KIND_ACK, channel: resp_ch_q, status: resp_st_q,
					              last: 1'b1};
				end
			end
			S_SEEK: begin
				if (head_q != target_q) begin
					shift_en = 1'b1;
				end else if (func_q != FN_TICK && evt_free) begin
					shift_en  = 1'b1;
					act       = 1'b1;
					push      = 1'b1;
					push_data = '{kind: KIND_ACK, channel: resp_ch_q, status: ST_OK,
					              last: 1'b1};
					case (func_q) inside
						FN_CREATE, FN_CREATE_ARM: begin
							tail_flags = '{exists: 1'b1, active: 1'b0, periodic: rep_q,
							               armed: 1'b0};
							if (func_q == FN_CREATE_ARM) begin
								tail_flags.active = 1'b1;
								tail_flags.armed  = 1'b1;
								tail_int          = dur_q;
								tail_rem          = dur_q;
							end
						end
						FN_ARM: begin
							if (!head_flags.exists) begin
								push_data.status = ST_NOCHAN;
							end else begin
								tail_flags.active   = 1'b1;
								tail_flags.armed    = 1'b1;
								tail_flags.periodic = rep_q;
								tail_int            = dur_q;
								tail_rem            = dur_q;
							end
						end
						FN_CANCEL: begin
							if (!head_flags.exists) begin
								push_data.status = ST_NOCHAN;
							end else begin
								tail_flags.active = 1'b0;
							end
						end
						default: begin
							// restart
							if (!head_flags.exists) begin
								push_data.status = ST_NOCHAN;
							end else if (!head_flags.armed) begin
								push_data.status = ST_NOTARMED;
							end else begin
								tail_flags.active = 1'b1;
								tail_rem          = head_int;
							end
						end
					endcase
				end
			end
			S_SWEEP: begin
				// Hold while a new expiry would displace a pending one that cannot leave
				if (!(head_exp && pend_valid_q && !evt_free)) begin
					shift_en = 1'b1;
					if (head_flags.exists && head_flags.active) begin
						if (head_exp) begin
							if (head_flags.periodic) begin
								tail_rem = head_int;
							end else begin
								tail_flags.active = 1'b0;
								tail_rem          = '0;
							end
						end else begin
							tail_rem = head_rem - COUNT_BITS'(1);
						end
					end
					if (head_exp && pend_valid_q) begin
						push      = 1'b1;
						push_data = '{kind: KIND_EXPIRY, channel: pend_ch_q, status: ST_OK,
						              last: 1'b0};
					end
				end
			end
			S_FLUSH: begin
				if (pend_valid_q && evt_free) begin
					push      = 1'b1;
					push_data = '{kind: KIND_EXPIRY, channel: pend_ch_q, status: ST_OK,
					              last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	// Controller state, head position and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			target_q     <= '0;
			next_free_q  <= '0;
			func_q       <= FN_CREATE;
			dur_q        <= '0;
			rep_q        <= 1'b0;
			resp_ch_q    <= '0;
			resp_st_q    <= ST_OK;
			pend_valid_q <= 1'b0;
			pend_ch_q    <= '0;
			evt_valid_q  <= 1'b0;
			evt_q        <= '0;
		end else begin
			if (push) begin
				evt_valid_q <= 1'b1;
				evt_q       <= push_data;
			end else if (evt_ready) begin
				evt_valid_q <= 1'b0;
			end

			if (shift_en) begin
				head_q <= (head_q == LAST_CH) ? '0 : head_q + CH_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						func_q <= cmd.func;
						dur_q  <= dur_wide[COUNT_BITS-1:0];
						rep_q  <= cmd.repeat_req;
						case (cmd.func) inside
							FN_CREATE, FN_CREATE_ARM: begin
								if (table_full) begin
									resp_ch_q <= '0;
									resp_st_q <= ST_FULL;
									state_q   <= S_RESP;
								end else begin
									resp_ch_q <= nf_ext[3:0];
									target_q  <= nf_ext[CH_W-1:0];
									state_q   <= S_SEEK;
								end
							end
							FN_ARM, FN_CANCEL, FN_RESTART: begin
								resp_ch_q <= cmd.timer_id;
								if (id_ok) begin
									target_q <= id_ext[CH_W-1:0];
									state_q  <= S_SEEK;
								end else begin
									resp_st_q <= ST_NOCHAN;
									state_q   <= S_RESP;
								end
							end
							FN_TICK: begin
								target_q <= '0;
								state_q  <= S_SEEK;
							end
							default: begin
							end
						endcase
					end
				end
				S_RESP: begin
					if (push) begin
						state_q <= S_IDLE;
					end
				end
				S_SEEK: begin
					if (head_q == target_q) begin
						if (func_q == FN_TICK) begin
							state_q <= S_SWEEP;
						end else if (act) begin
							if (func_q == FN_CREATE || func_q == FN_CREATE_ARM) begin
								next_free_q <= next_free_q + NF_W'(1);
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_SWEEP: begin
					if (shift_en) begin
						if (head_exp) begin
							pend_valid_q <= 1'b1;
							pend_ch_q    <= head_ext[3:0];
						end
						if (head_q == LAST_CH) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (push) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

endmodule

`default_nettype wire
